// ===== src/cbe_pkg.sv =====
// Package for the chain bus enumerator: phase codes, bus transaction kinds,
// configuration register indexes, reset values and the slave table size.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package cbe_pkg;

	// Number of slave entries the table can hold (1 to 15).
	localparam int unsigned TABLE_SLOTS = 8;
	localparam int unsigned REG_CNT_W   = 4;

	// Enumeration phases.
	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_WAIT_PULSE  = 3'd1;
	localparam logic [2:0] PH_WAIT_SET_ID = 3'd2;
	localparam logic [2:0] PH_CONFIRM     = 3'd3;
	localparam logic [2:0] PH_DONE        = 3'd4;

	// Kind of bus transaction issued in a step.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SET_ID = 2'd1;
	localparam logic [1:0] KIND_PING   = 2'd2;

	// Request types on the input stream.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_FIRST_PULSE = 3'd0;
	localparam logic [2:0] REG_RESPONSE    = 3'd1;
	localparam logic [2:0] REG_MOVE        = 3'd2;
	localparam logic [2:0] REG_NEXT_PULSE  = 3'd3;
	localparam logic [2:0] REG_RETRY       = 3'd4;
	localparam logic [2:0] REG_DEFAULT_ADR = 3'd5;
	localparam logic [2:0] REG_BASE_ADR    = 3'd6;

	// Configuration reset values.
	localparam logic [15:0] RST_FIRST_PULSE = 16'd1000;
	localparam logic [15:0] RST_RESPONSE    = 16'd100;
	localparam logic [15:0] RST_MOVE        = 16'd50;
	localparam logic [15:0] RST_NEXT_PULSE  = 16'd100;
	localparam logic [15:0] RST_RETRY       = 16'd1000;
	localparam logic [6:0]  RST_DEFAULT_ADR = 7'h60;
	localparam logic [6:0]  RST_BASE_ADR    = 7'd16;

	// One result transaction.
	typedef struct packed {
		logic                 finished;
		logic                 complete;
		logic [REG_CNT_W-1:0] slave_total;
		logic [6:0]           added_address;
		logic [7:0]           added_id;
		logic                 added;
		logic [7:0]           bus_id;
		logic [6:0]           bus_address;
		logic [2:0]           phase;
	} result_t;

endpackage

`default_nettype wire

// ===== src/chain_bus_enumerator_top.sv =====
// Top level of the chain bus enumerator: stream input, stream output,
// APB-style configuration port and the whole enumeration state machine.
// Depends on cbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block is the master side of a daisy-chain enumeration. Each input
// transaction is either a start request (tuser = 0), which clears the slave
// count and arms the first-pulse timeout, or a one-millisecond tick
// (tuser = 1) carrying the enable-chain level and the ack results of the bus
// transaction the block issues in that same step. Every input transaction
// produces exactly one result transaction telling the bus master what to
// issue (a SET_ID write to the default address or a ping plus status read at
// base address + ID - 1), whether a slave was registered and the new phase.
// The step is evaluated combinationally from the state registers and the
// incoming transaction, and the result is captured in an output register, so
// a transaction is accepted every cycle; the only limit is the output
// register, which takes a new result while the old one is being taken in the
// same cycle. Configuration registers sit at byte addresses 0, 4, ... 24 and
// must only be written while no result is outstanding; a new timeout value
// takes effect at the next time the countdown is loaded.
module chain_bus_enumerator_top import cbe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] chain_level, [1] write_ack, [2] read_ack
	input  wire logic [0:0]  s_tuser,   // [0] req_type
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [2:0] phase, [9:3] bus_address, [17:10] bus_id,
	                                    // [18] added, [26:19] added_id,
	                                    // [33:27] added_address, [37:34] slave_total,
	                                    // [38] complete, [39] finished
	output logic [1:0]       m_tuser,   // [1:0] bus_kind
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Configuration registers.
	logic [15:0] first_pulse_q, response_q, move_q, next_pulse_q, retry_q;
	logic [6:0]  default_adr_q, base_adr_q;

	// Enumeration state.
	logic [2:0]           phase_q;
	logic [15:0]          time_left_q;
	logic [7:0]           pulse_count_q;
	logic                 last_level_q;
	logic [7:0]           pending_id_q;
	logic [REG_CNT_W-1:0] registered_q;

	// Output register.
	logic    out_valid_q;
	result_t out_res_q;
	logic [1:0] out_kind_q;

	// Next-state and result of the current step.
	logic [2:0]           phase_d;
	logic [15:0]          time_left_d;
	logic [7:0]           pulse_count_d;
	logic                 last_level_d;
	logic [7:0]           pending_id_d;
	logic [REG_CNT_W-1:0] registered_d;
	result_t              res_d;
	logic [1:0]           kind_d;
	logic [15:0]          tl_dec;
	logic [7:0]           pulse_inc;
	logic [6:0]           ping_adr;
	logic                 in_fire;
	logic                 cfg_wr;
	logic                 lvl, wack, rack;

	assign pready   = 1'b1;
	assign s_tready = !out_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_res_q;
	assign m_tuser  = out_kind_q;

	assign lvl  = s_tdata[0];
	assign wack = s_tdata[1];
	assign rack = s_tdata[2];

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pulse_q <= RST_FIRST_PULSE;
			response_q    <= RST_RESPONSE;
			move_q        <= RST_MOVE;
			next_pulse_q  <= RST_NEXT_PULSE;
			retry_q       <= RST_RETRY;
			default_adr_q <= RST_DEFAULT_ADR;
			base_adr_q    <= RST_BASE_ADR;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_FIRST_PULSE: first_pulse_q <= pwdata[15:0];
				REG_RESPONSE:    response_q    <= pwdata[15:0];
				REG_MOVE:        move_q        <= pwdata[15:0];
				REG_NEXT_PULSE:  next_pulse_q  <= pwdata[15:0];
				REG_RETRY:       retry_q       <= pwdata[15:0];
				REG_DEFAULT_ADR: default_adr_q <= pwdata[6:0];
				REG_BASE_ADR:    base_adr_q    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_FIRST_PULSE: prdata = {16'd0, first_pulse_q};
			REG_RESPONSE:    prdata = {16'd0, response_q};
			REG_MOVE:        prdata = {16'd0, move_q};
			REG_NEXT_PULSE:  prdata = {16'd0, next_pulse_q};
			REG_RETRY:       prdata = {16'd0, retry_q};
			REG_DEFAULT_ADR: prdata = {25'd0, default_adr_q};
			REG_BASE_ADR:    prdata = {25'd0, base_adr_q};
			default:         prdata = '0;
		endcase
	end

	// Every tick in an active phase counts the timeout down, stopping at zero.
	assign tl_dec    = (time_left_q != 16'd0) ? time_left_q - 16'd1 : time_left_q;
	assign pulse_inc = pulse_count_q + 8'd1;
	// Slave ID one lives at the base address, so the ping goes to base + ID - 1.
	assign ping_adr  = base_adr_q + pending_id_q[6:0] - 7'd1;

	always_comb begin
		phase_d       = phase_q;
		time_left_d   = time_left_q;
		pulse_count_d = pulse_count_q;
		last_level_d  = last_level_q;
		pending_id_d  = pending_id_q;
		registered_d  = registered_q;
		kind_d        = KIND_NONE;
		res_d         = '0;

		if (s_tuser[0] == REQ_START) begin
			// A start is taken in any phase and restarts the run.
			registered_d  = '0;
			phase_d       = PH_WAIT_PULSE;
			pulse_count_d = '0;
			last_level_d  = 1'b0;
			pending_id_d  = 8'd1;
			time_left_d   = first_pulse_q;
		end else begin
			unique case (phase_q)
				PH_WAIT_PULSE: begin
					time_left_d = tl_dec;
					if (!last_level_q && lvl) begin
						// Rising edge on the chain: hand out the next ID.
						pulse_count_d = pulse_inc;
						pending_id_d  = pulse_inc;
						phase_d       = PH_WAIT_SET_ID;
						time_left_d   = response_q;
					end
					last_level_d = lvl;
					// The timeout check sees the freshly loaded count, so a zero
					// response timeout ends the run right after a pulse.
					if (time_left_d == 16'd0 && pulse_count_d != 8'd0) begin
						phase_d = PH_DONE;
					end
				end
				PH_WAIT_SET_ID: begin
					time_left_d       = tl_dec;
					kind_d            = KIND_SET_ID;
					res_d.bus_address = default_adr_q;
					res_d.bus_id      = pending_id_q;
					if (wack) begin
						phase_d     = PH_CONFIRM;
						time_left_d = move_q;
					end else if (tl_dec == 16'd0) begin
						phase_d     = PH_WAIT_PULSE;
						time_left_d = retry_q;
					end
				end
				PH_CONFIRM: begin
					time_left_d       = tl_dec;
					kind_d            = KIND_PING;
					res_d.bus_address = ping_adr;
					if (wack && rack) begin
						// A full table still returns to waiting, it just adds nothing.
						if (registered_q < REG_CNT_W'(TABLE_SLOTS)) begin
							res_d.added         = 1'b1;
							res_d.added_id      = pending_id_q;
							res_d.added_address = ping_adr;
							registered_d        = registered_q + REG_CNT_W'(1);
						end
						phase_d     = PH_WAIT_PULSE;
						time_left_d = next_pulse_q;
					end else if (tl_dec == 16'd0) begin
						phase_d     = PH_WAIT_PULSE;
						time_left_d = retry_q;
					end
				end
				PH_DONE: begin
					res_d.finished = 1'b1;
				end
				default: ;
			endcase
		end

		res_d.phase       = phase_d;
		res_d.slave_total = registered_d;
		res_d.complete    = (phase_d == PH_IDLE) || (phase_d == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			time_left_q   <= '0;
			pulse_count_q <= '0;
			last_level_q  <= 1'b0;
			pending_id_q  <= '0;
			registered_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q       <= phase_d;
				time_left_q   <= time_left_d;
				pulse_count_q <= pulse_count_d;
				last_level_q  <= last_level_d;
				pending_id_q  <= pending_id_d;
				registered_q  <= registered_d;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_res_q  <= res_d;
			out_kind_q <= kind_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/cbe_checker.sv =====
// Port-level checker for the chain bus enumerator and its bind to the top.
// Depends on cbe_pkg and chain_bus_enumerator_top.
`timescale 1ns / 1ps
`default_nettype none

module cbe_port_checker import cbe_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// A stalled result must hold its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A registration only happens on a successful ping and returns to waiting.
	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> m_tuser == KIND_PING && m_tdata[2:0] == PH_WAIT_PULSE)
		else $error("slave added outside a ping step");

	// Finished only comes from the done phase, which always reports complete.
	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39] |-> m_tdata[2:0] == PH_DONE && m_tdata[38])
		else $error("finished without done phase");

	// The slave count never exceeds the table.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:34] <= REG_CNT_W'(TABLE_SLOTS))
		else $error("slave total beyond table size");

endmodule

bind chain_bus_enumerator_top cbe_port_checker u_cbe_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/cbe_checker.sv =====
`timescale 1ns / 1ps
// Checker for the chain bus enumerator: watches both streams and the
// configuration port, predicts each result transaction and compares it.
// Depends on cbe_pkg.
module cbe_checker import cbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] chain_level, [1] write_ack, [2] read_ack
	input  logic [0:0]  s_tuser,   // [0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // phase, bus_address, bus_id, added, added_id,
	                               // added_address, slave_total, complete, finished
	input  logic [1:0]  m_tuser,   // [1:0] bus_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0] kind;
		result_t    fields;
	} step_result_t;

	// Settings as last written through the configuration port.
	logic [15:0] first_pulse_ms, response_ms, move_ms, next_pulse_ms, retry_ms;
	logic [6:0]  default_adr, base_adr;

	// Enumeration state.
	logic [2:0]  cur_phase;
	logic [15:0] ms_left;
	logic [7:0]  pulse_count;
	logic        chain_prev;
	logic [7:0]  slave_id;
	logic [3:0]  slave_count;

	step_result_t expected_results[$];
	step_result_t want, got;
	int mismatch_total;
	int results_checked;

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("%0t: result %0d, %s mismatch: expected %0d, got %0d",
					$realtime, results_checked, name, exp_val, act_val);
		end
	endtask

	// One step of the enumeration: updates the state and returns the result.
	task automatic advance_enumerator(input logic req, input logic level,
			input logic write_ack, input logic read_ack, output step_result_t step);
		logic [6:0] target;
		step = '0;
		if (req == REQ_START) begin
			slave_count = '0;
			cur_phase   = PH_WAIT_PULSE;
			pulse_count = '0;
			chain_prev  = 1'b0;
			slave_id    = 8'd1;
			ms_left     = first_pulse_ms;
		end else if (cur_phase == PH_DONE) begin
			step.fields.finished = 1'b1;
		end else if (cur_phase != PH_IDLE) begin
			if (ms_left != 0)
				ms_left--;
			case (cur_phase)
				PH_WAIT_PULSE: begin
					if (!chain_prev && level) begin
						pulse_count++;
						slave_id  = pulse_count;
						cur_phase = PH_WAIT_SET_ID;
						ms_left   = response_ms;
					end
					chain_prev = level;
					// The expiry check sees a countdown freshly loaded by an edge.
					if (ms_left == 0 && pulse_count != 0)
						cur_phase = PH_DONE;
				end
				PH_WAIT_SET_ID: begin
					step.kind               = KIND_SET_ID;
					step.fields.bus_address = default_adr;
					step.fields.bus_id      = slave_id;
					if (write_ack) begin
						cur_phase = PH_CONFIRM;
						ms_left   = move_ms;
					end else if (ms_left == 0) begin
						cur_phase = PH_WAIT_PULSE;
						ms_left   = retry_ms;
					end
				end
				default: begin
					target                  = base_adr + slave_id[6:0] - 7'd1;
					step.kind               = KIND_PING;
					step.fields.bus_address = target;
					if (write_ack && read_ack) begin
						if (slave_count < TABLE_SLOTS) begin
							step.fields.added         = 1'b1;
							step.fields.added_id      = slave_id;
							step.fields.added_address = target;
							slave_count++;
						end
						cur_phase = PH_WAIT_PULSE;
						ms_left   = next_pulse_ms;
					end else if (ms_left == 0) begin
						cur_phase = PH_WAIT_PULSE;
						ms_left   = retry_ms;
					end
				end
			endcase
		end
		step.fields.phase       = cur_phase;
		step.fields.slave_total = slave_count;
		step.fields.complete    = (cur_phase == PH_IDLE || cur_phase == PH_DONE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pulse_ms  = RST_FIRST_PULSE;
			response_ms     = RST_RESPONSE;
			move_ms         = RST_MOVE;
			next_pulse_ms   = RST_NEXT_PULSE;
			retry_ms        = RST_RETRY;
			default_adr     = RST_DEFAULT_ADR;
			base_adr        = RST_BASE_ADR;
			cur_phase       = PH_IDLE;
			ms_left         = '0;
			pulse_count     = '0;
			chain_prev      = 1'b0;
			slave_id        = '0;
			slave_count     = '0;
			mismatch_total  = 0;
			results_checked = 0;
			expected_results.delete();
			failures    <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FIRST_PULSE: first_pulse_ms = pwdata[15:0];
					REG_RESPONSE:    response_ms    = pwdata[15:0];
					REG_MOVE:        move_ms        = pwdata[15:0];
					REG_NEXT_PULSE:  next_pulse_ms  = pwdata[15:0];
					REG_RETRY:       retry_ms       = pwdata[15:0];
					REG_DEFAULT_ADR: default_adr    = pwdata[6:0];
					REG_BASE_ADR:    base_adr       = pwdata[6:0];
					default: ;
				endcase
			end
			// Results leave from an output register after their input is accepted, so the
			// output side is handled before this edge's input transaction.
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser;
				got.fields = result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t: result transaction with nothing expected: kind %0d data 0x%0h",
							$realtime, got.kind, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("bus_kind", want.kind, got.kind);
					check_field("phase", want.fields.phase, got.fields.phase);
					check_field("bus_address", want.fields.bus_address, got.fields.bus_address);
					check_field("bus_id", want.fields.bus_id, got.fields.bus_id);
					check_field("added", want.fields.added, got.fields.added);
					check_field("added_id", want.fields.added_id, got.fields.added_id);
					check_field("added_address", want.fields.added_address,
						got.fields.added_address);
					check_field("slave_total", want.fields.slave_total, got.fields.slave_total);
					check_field("complete", want.fields.complete, got.fields.complete);
					check_field("finished", want.fields.finished, got.fields.finished);
				end
				results_checked++;
			end
			if (s_tvalid && s_tready) begin
				advance_enumerator(s_tuser[0], s_tdata[0], s_tdata[1], s_tdata[2], want);
				expected_results.push_back(want);
			end
			failures    <= mismatch_total;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the chain bus enumerator: clock, reset, input stream and
// configuration stimulus, output back-pressure and the final verdict.
// Depends on cbe_pkg, chain_bus_enumerator_top and cbe_checker.
module testbench;
	import cbe_pkg::*;

	// Address 28 decodes to no register; writes there must be ignored.
	localparam logic [2:0] REG_UNUSED  = 3'd7;
	// Length of the long output stall that fills the block up.
	localparam int         HOLD_CYCLES = 300;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [0] chain_level, [1] write_ack, [2] read_ack
	logic [0:0]  s_tuser  = '0;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int failure_total;
	int results_due;

	// Sender burst bookkeeping.
	int burst_left    = 0;
	bit allow_restart = 1'b1;

	// Receiver stall bookkeeping; a long hold is requested by bumping
	// hold_requests from the stimulus process.
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int stall_mode    = 0;
	int mode_left     = 0;

	chain_bus_enumerator_top dut (.*);

	cbe_checker result_checker (
		.*,
		.failures    (failure_total),
		.outstanding (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: switches between stall patterns at random intervals. A
	// requested long hold keeps tready low, so the output register stays
	// full and the input side has to stall.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left    = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				0: m_tready <= 1'b1;                            // never stalls
				1: m_tready <= ($urandom_range(0, 1) != 0);     // half the time
				2: m_tready <= ($urandom_range(0, 4) == 0);     // mostly stalled
				default: m_tready <= ~m_tready;                 // alternates
			endcase
		end
	end

	function automatic logic coin();
		return $urandom_range(0, 1) != 0;
	endfunction

	// Short timeouts make every expiry path show up within a few ticks;
	// now and then a zero timeout is chosen.
	function automatic logic [15:0] short_timeout();
		return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
	endfunction

	// Waits until every predicted result transaction has been taken.
	task automatic wait_for_drain();
		do @(posedge clk); while (results_due != 0);
	endtask

	// Offers one input transaction and returns at the edge that accepts it.
	// Transactions go out in bursts; between bursts valid drops for a random
	// gap, and once in a while the sender waits for the block to empty.
	task automatic drive_transaction(input logic req, input logic level,
			input logic wack, input logic rack);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 24) == 0)
				wait_for_drain();
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {5'd0, rack, wack, level};
		do @(posedge clk); while (!s_tready);
	endtask

	// A tick with the intended content, except that a few are scrambled and,
	// where allowed, one in a hundred becomes a restart.
	task automatic noisy_tick(input logic level, input logic wack, input logic rack);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll == 0 && allow_restart)
			drive_transaction(REQ_START, coin(), coin(), coin());
		else if (roll < 7)
			drive_transaction(REQ_TICK, coin(), coin(), coin());
		else
			drive_transaction(REQ_TICK, level, wack, rack);
	endtask

	// One APB write; psel stays high so writes can follow back to back.
	task automatic write_register(input logic [2:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Stops the stream, lets the block empty, then rewrites every register.
	// Upper data bits carry junk, which the registers must drop.
	task automatic apply_settings(input logic [15:0] first_ms, input logic [15:0] resp_ms,
			input logic [15:0] move_ms, input logic [15:0] next_ms,
			input logic [15:0] retry_ms, input logic [6:0] default_adr,
			input logic [6:0] base_adr);
		s_tvalid <= 1'b0;
		wait_for_drain();
		write_register(REG_FIRST_PULSE, {16'($urandom), first_ms});
		write_register(REG_RESPONSE,    {16'($urandom), resp_ms});
		write_register(REG_MOVE,        {16'($urandom), move_ms});
		write_register(REG_NEXT_PULSE,  {16'($urandom), next_ms});
		write_register(REG_RETRY,       {16'($urandom), retry_ms});
		write_register(REG_DEFAULT_ADR, {25'($urandom), default_adr});
		write_register(REG_BASE_ADR,    {25'($urandom), base_adr});
		write_register(REG_UNUSED,      $urandom);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A well-formed enumeration: start, then per slave a low level, a rising
	// edge, a SET_ID write that succeeds after some misses and a ping that
	// succeeds after some misses; then a tail of quiet ticks. The quick form
	// keeps one tick per stage and mostly lets the SET_ID write time out, so
	// that many pulses fit into few transactions.
	task automatic run_enumeration(input int pulses, input int tail, input bit quick);
		logic [1:0] acks;
		drive_transaction(REQ_START, coin(), coin(), coin());
		repeat (pulses) begin
			repeat (quick ? 1 : $urandom_range(1, 3))
				noisy_tick(1'b0, coin(), coin());
			noisy_tick(1'b1, coin(), coin());
			if (quick && $urandom_range(0, 9) < 7) begin
				noisy_tick(coin(), 1'b0, coin());
			end else begin
				repeat (quick ? 0 : $urandom_range(0, 2))
					noisy_tick(coin(), 1'b0, coin());
				noisy_tick(coin(), 1'b1, coin());
				// Ping misses: no ack, a read ack without the write, or a write ack without the read.
				repeat (quick ? 0 : $urandom_range(0, 2)) begin
					acks = 2'($urandom_range(0, 2));
					noisy_tick(coin(), acks[1], acks[0]);
				end
				noisy_tick(coin(), 1'b1, 1'b1);
			end
		end
		repeat (tail)
			noisy_tick(1'b0, coin(), coin());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset values. A tick while idle changes nothing, and a
		// start ignores its other fields.
		drive_transaction(REQ_TICK,  1'b1, 1'b1, 1'b1);
		drive_transaction(REQ_START, 1'b1, 1'b1, 1'b1);
		// Rising edge assigns ID one; the SET_ID write misses once, then lands.
		drive_transaction(REQ_TICK,  1'b1, 1'b0, 1'b0);
		drive_transaction(REQ_TICK,  1'b0, 1'b0, 1'b0);
		drive_transaction(REQ_TICK,  1'b0, 1'b1, 1'b0);
		// The ping: a missing read ack, then a read ack without the write ack,
		// then both, which registers the slave.
		drive_transaction(REQ_TICK,  1'b0, 1'b1, 1'b0);
		drive_transaction(REQ_TICK,  1'b0, 1'b0, 1'b1);
		drive_transaction(REQ_TICK,  1'b0, 1'b1, 1'b1);
		// The level still high from the edge is no new edge; low then high is.
		drive_transaction(REQ_TICK,  1'b1, 1'b0, 1'b0);
		drive_transaction(REQ_TICK,  1'b0, 1'b0, 1'b0);
		drive_transaction(REQ_TICK,  1'b1, 1'b0, 1'b0);
		// A start in the middle of a run restarts it.
		drive_transaction(REQ_START, 1'b0, 1'b0, 1'b0);

		// Directed, all timeouts zero. Without a pulse the expired first
		// timeout keeps the block waiting; the first edge then ends the run at
		// once, and a tick after that reports finished.
		apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 7'd127);
		drive_transaction(REQ_START, 1'b0, 1'b1, 1'b0);
		drive_transaction(REQ_TICK,  1'b0, 1'b1, 1'b1);
		drive_transaction(REQ_TICK,  1'b1, 1'b0, 1'b1);
		drive_transaction(REQ_TICK,  1'b1, 1'b1, 1'b1);
		drive_transaction(REQ_START, 1'b1, 1'b0, 1'b0);

		// Random enumerations under short timeouts, so runs hit every expiry.
		// In the second setting the receiver holds off for a long stretch
		// while the sender keeps offering.
		for (int setting = 0; setting < 5; setting++) begin
			apply_settings(short_timeout(), short_timeout(), short_timeout(),
				short_timeout(), short_timeout(), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)));
			if (setting == 1)
				hold_requests++;
			repeat (2)
				run_enumeration($urandom_range(0, 10), $urandom_range(0, 8), 1'b0);
		end

		// Longest timeouts and the top default address: ten slaves overflow
		// the table, and the last pulses are acknowledged but not registered.
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 7'd0);
		run_enumeration(10, 3, 1'b0);

		// Enough pulses in one run to wrap the ID past 255; with the base
		// address at the top, the slave addresses wrap as well. A restart
		// would clear the pulse count, so none is sent here.
		allow_restart = 1'b0;
		apply_settings(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF,
			7'($urandom_range(0, 127)), 7'd127);
		run_enumeration(262, 2, 1'b1);
		allow_restart = 1'b1;

		// Unstructured transactions with occasional restarts.
		apply_settings(short_timeout(), short_timeout(), short_timeout(),
			short_timeout(), short_timeout(), 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)));
		drive_transaction(REQ_START, coin(), coin(), coin());
		repeat (150)
			drive_transaction(($urandom_range(0, 19) == 0) ? REQ_START : REQ_TICK,
				coin(), coin(), coin());

		// Let every result come out, then keep watching the output in case
		// the block produces a result nobody asked for.
		s_tvalid <= 1'b0;
		wait_for_drain();
		repeat (16) @(posedge clk);
		if (failure_total == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cbe_pkg.sv
src/chain_bus_enumerator_top.sv
src/cbe_checker.sv
dv/cbe_checker.sv
dv/testbench.sv
